[src/hrhp_pkg.sv]
// Package for the HTTP response header parser: word types, phase codes,
// match patterns and the saturating accumulate helpers. No dependencies.
package hrhp_pkg;

	// Width of the length, chunk and body counters
	localparam int LEN_BITS = 32;
	typedef logic [LEN_BITS-1:0] len_t;
	localparam len_t LEN_MAX = '1;

	// Input word
	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} item_t;

	// Result word
	typedef struct packed {
		logic [3:0]  phase;
		logic        body_valid;
		logic [7:0]  body_byte;
		logic [15:0] status_code;
		logic [31:0] content_length;
		logic        has_length;
		logic        chunked;
		logic [31:0] chunk_remaining;
		logic [31:0] body_count;
		logic        body_done;
		logic        status_ok;
	} result_t;

	// Function codes of the input word
	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// Phase codes as reported in the result word
	localparam logic [3:0] PH_PREFIX = 4'd0;
	localparam logic [3:0] PH_CODE   = 4'd1;
	localparam logic [3:0] PH_REST   = 4'd2;
	localparam logic [3:0] PH_LINE   = 4'd3;
	localparam logic [3:0] PH_LEN    = 4'd4;
	localparam logic [3:0] PH_SKIP   = 4'd5;
	localparam logic [3:0] PH_CR     = 4'd6;
	localparam logic [3:0] PH_BODY   = 4'd7;
	localparam logic [3:0] PH_CSIZE  = 4'd8;
	localparam logic [3:0] PH_CDATA  = 4'd9;
	localparam logic [3:0] PH_ERROR  = 4'd10;

	// Parser state, one-hot
	typedef enum logic [10:0] {
		ST_PREFIX = 11'b000_0000_0001,
		ST_CODE   = 11'b000_0000_0010,
		ST_REST   = 11'b000_0000_0100,
		ST_LINE   = 11'b000_0000_1000,
		ST_LEN    = 11'b000_0001_0000,
		ST_SKIP   = 11'b000_0010_0000,
		ST_CR     = 11'b000_0100_0000,
		ST_BODY   = 11'b000_1000_0000,
		ST_CSIZE  = 11'b001_0000_0000,
		ST_CDATA  = 11'b010_0000_0000,
		ST_ERROR  = 11'b100_0000_0000
	} state_t;

	// Characters
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF_A = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;

	// Status codes
	localparam logic [15:0] CODE_FINAL_MIN = 16'd200;
	localparam logic [15:0] CODE_SWITCHING = 16'd101;

	// Patterns
	localparam int PREFIX_LEN = 9;
	localparam int CL_LEN     = 16;
	localparam int TE_LEN     = 26;
	localparam logic [8*CL_LEN-1:0] CL_PAT = "Content-Length: ";
	localparam logic [8*TE_LEN-1:0] TE_PAT = "Transfer-Encoding: chunked";

	function automatic logic [3:0] phase_code(state_t st);
		logic [3:0] code;
		unique case (st)
			ST_PREFIX: code = PH_PREFIX;
			ST_CODE:   code = PH_CODE;
			ST_REST:   code = PH_REST;
			ST_LINE:   code = PH_LINE;
			ST_LEN:    code = PH_LEN;
			ST_SKIP:   code = PH_SKIP;
			ST_CR:     code = PH_CR;
			ST_BODY:   code = PH_BODY;
			ST_CSIZE:  code = PH_CSIZE;
			ST_CDATA:  code = PH_CDATA;
			default:   code = PH_ERROR;
		endcase
		return code;
	endfunction

	// "HTTP/x.y " with any byte at both version digits
	function automatic logic prefix_hit(logic [3:0] idx, logic [7:0] c);
		logic hit;
		unique case (idx) inside
			4'd0:       hit = (c == 8'h48);
			4'd1, 4'd2: hit = (c == 8'h54);
			4'd3:       hit = (c == 8'h50);
			4'd4:       hit = (c == 8'h2F);
			4'd5, 4'd7: hit = 1'b1;
			4'd6:       hit = (c == 8'h2E);
			4'd8:       hit = (c == 8'h20);
			default:    hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic cl_hit(logic [4:0] idx, logic [7:0] c);
		logic hit;
		hit = 1'b0;
		if (int'(idx) < CL_LEN) begin
			hit = (CL_PAT[8*(CL_LEN-1-int'(idx)) +: 8] == c);
		end
		return hit;
	endfunction

	function automatic logic te_hit(logic [4:0] idx, logic [7:0] c);
		logic hit;
		hit = 1'b0;
		if (int'(idx) < TE_LEN) begin
			hit = (TE_PAT[8*(TE_LEN-1-int'(idx)) +: 8] == c);
		end
		return hit;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// Bit 4 flags a hex digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, 4'(c - CH_0)};
		end else if (c >= CH_LA && c <= CH_LF_A) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end
		return r;
	endfunction

	// v*10 + d, saturating
	function automatic len_t len_mac10(len_t v, logic [3:0] d);
		logic [LEN_BITS+3:0] p;
		p = ({4'd0, v} << 3) + ({4'd0, v} << 1) + (LEN_BITS+4)'(d);
		return (p[LEN_BITS+3:LEN_BITS] != 4'd0) ? LEN_MAX : p[LEN_BITS-1:0];
	endfunction

	// v*16 + h, saturating
	function automatic len_t len_mac16(len_t v, logic [3:0] h);
		return (v[LEN_BITS-1:LEN_BITS-4] != 4'd0) ? LEN_MAX : {v[LEN_BITS-5:0], h};
	endfunction

	// Status code v*10 + d, saturating at 16 bits
	function automatic logic [15:0] code_mac10(logic [15:0] v, logic [3:0] d);
		logic [19:0] p;
		p = ({4'd0, v} << 3) + ({4'd0, v} << 1) + 20'(d);
		return (p[19:16] != 4'd0) ? 16'hFFFF : p[15:0];
	endfunction

endpackage

[src/http_response_header_parser.sv]
// HTTP response header parser top level: one received byte per input word.
// Depends on hrhp_pkg (types, phase codes, patterns, saturating helpers).
//
//  channel | handshake                 | payload            | direction
//  --------+---------------------------+--------------------+----------
//  item    | item_valid / item_stall   | hrhp_pkg::item_t   | into block
//  result  | result_valid/result_stall | hrhp_pkg::result_t | out of block
//
// Every input word yields exactly one result word, registered: the result
// appears in the cycle after the word is taken. While nothing stalls, throughput
// is one word per cycle, set by the single parser state update.
// item_stall rises only while the result register holds a word that is stalled.
// arst_n clears the parser state and the result valid flag at once.
// A restart word returns every piece of parser state to its reset value.
module http_response_header_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  hrhp_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output hrhp_pkg::result_t   result
);

	// Parser state
	hrhp_pkg::state_t   st_q, st_d;
	logic [3:0]         pidx_q, pidx_d;       // status prefix position
	logic [4:0]         lidx_q, lidx_d;       // Content-Length match position
	logic [4:0]         eidx_q, eidx_d;       // Transfer-Encoding match position
	logic [15:0]        code_q, code_d;
	hrhp_pkg::len_t     len_q, len_d;
	logic               seen_q, seen_d;
	logic               chnk_q, chnk_d;
	hrhp_pkg::len_t     left_q, left_d;
	hrhp_pkg::len_t     cons_q, cons_d;
	logic               final_q, final_d;

	// Result register
	logic               res_valid_q;
	hrhp_pkg::result_t  res_q, res_d;

	logic               accept;
	logic [7:0]         c;
	logic               bvalid;
	logic               count_en;
	logic               informational;
	logic [4:0]         hex;
	logic               in_body;

	// Stall the input only when a finished result is held back downstream
	assign item_stall = res_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign c          = item.rx_byte;

	// Body bytes count only once a positive length is known; hold at the top
	assign count_en = seen_q && (len_q != '0) && (cons_q != hrhp_pkg::LEN_MAX);

	// A code below 200 other than 101 is an interim response: drop the line
	assign informational = (code_q < hrhp_pkg::CODE_FINAL_MIN) &&
		(code_q != hrhp_pkg::CODE_SWITCHING);

	assign hex = hrhp_pkg::hex_digit(c);

	// Next-state logic for one byte
	always_comb begin
		st_d    = st_q;
		pidx_d  = pidx_q;
		lidx_d  = lidx_q;
		eidx_d  = eidx_q;
		code_d  = code_q;
		len_d   = len_q;
		seen_d  = seen_q;
		chnk_d  = chnk_q;
		left_d  = left_q;
		cons_d  = cons_q;
		final_d = final_q;
		bvalid  = 1'b0;

		if (item.func == hrhp_pkg::FUNC_RESTART) begin
			// Restart: everything back to the reset picture
			st_d    = hrhp_pkg::ST_PREFIX;
			pidx_d  = '0;
			lidx_d  = '0;
			eidx_d  = '0;
			code_d  = '0;
			len_d   = '0;
			seen_d  = 1'b0;
			chnk_d  = 1'b0;
			left_d  = '0;
			cons_d  = '0;
			final_d = 1'b0;
		end else begin
			unique case (st_q) inside
				hrhp_pkg::ST_PREFIX: begin
					// An LF is never part of the prefix, not even at a wildcard
					if (c != hrhp_pkg::CH_LF && hrhp_pkg::prefix_hit(pidx_q, c)) begin
						pidx_d = pidx_q + 4'd1;
						if (pidx_q == 4'(hrhp_pkg::PREFIX_LEN - 1)) begin
							st_d = hrhp_pkg::ST_CODE;
						end
					end else begin
						st_d = hrhp_pkg::ST_ERROR;
					end
				end
				hrhp_pkg::ST_CODE, hrhp_pkg::ST_REST: begin
					if (st_q == hrhp_pkg::ST_CODE && hrhp_pkg::is_digit(c)) begin
						code_d = hrhp_pkg::code_mac10(code_q, c[3:0]);
					end else if (c == hrhp_pkg::CH_LF) begin
						// End of status line: interim lines go back to the prefix
						if (informational) begin
							code_d = '0;
							pidx_d = '0;
							st_d   = hrhp_pkg::ST_PREFIX;
						end else begin
							final_d = 1'b1;
							lidx_d  = '0;
							eidx_d  = '0;
							st_d    = hrhp_pkg::ST_LINE;
						end
					end else if (st_q == hrhp_pkg::ST_CODE) begin
						st_d = hrhp_pkg::ST_REST;
					end
				end
				hrhp_pkg::ST_LINE, hrhp_pkg::ST_LEN, hrhp_pkg::ST_SKIP,
				hrhp_pkg::ST_CR: begin
					if (st_q == hrhp_pkg::ST_LINE) begin
						// Content-Length has priority over Transfer-Encoding
						if (hrhp_pkg::cl_hit(lidx_q, c)) begin
							lidx_d = lidx_q + 5'd1;
							if (lidx_q == 5'(hrhp_pkg::CL_LEN - 1)) begin
								st_d   = hrhp_pkg::ST_LEN;
								len_d  = '0;
								cons_d = '0;
								seen_d = 1'b1;
							end
						end else if (hrhp_pkg::te_hit(eidx_q, c)) begin
							eidx_d = eidx_q + 5'd1;
							if (eidx_q == 5'(hrhp_pkg::TE_LEN - 1)) begin
								chnk_d = 1'b1;
								st_d   = hrhp_pkg::ST_SKIP;
							end
						end else if (lidx_q == '0 && eidx_q == '0 && c == hrhp_pkg::CH_CR) begin
							st_d = hrhp_pkg::ST_CR;
						end else begin
							st_d = hrhp_pkg::ST_SKIP;
						end
					end else if (st_q == hrhp_pkg::ST_LEN) begin
						if (hrhp_pkg::is_digit(c)) begin
							len_d = hrhp_pkg::len_mac10(len_q, c[3:0]);
						end else begin
							st_d = hrhp_pkg::ST_SKIP;
						end
					end else if (st_q == hrhp_pkg::ST_CR && c == hrhp_pkg::CH_LF) begin
						// Empty line: headers are over
						if (chnk_q) begin
							st_d   = hrhp_pkg::ST_CSIZE;
							left_d = '0;
						end else begin
							st_d = hrhp_pkg::ST_BODY;
						end
					end
					// Any other LF starts a fresh header line
					if (c == hrhp_pkg::CH_LF && st_d != hrhp_pkg::ST_BODY &&
						st_d != hrhp_pkg::ST_CSIZE) begin
						st_d   = hrhp_pkg::ST_LINE;
						lidx_d = '0;
						eidx_d = '0;
					end
				end
				hrhp_pkg::ST_BODY: begin
					bvalid = 1'b1;
					if (count_en) begin
						cons_d = cons_q + hrhp_pkg::len_t'(1);
					end
				end
				hrhp_pkg::ST_CSIZE: begin
					// CR and stray bytes are dropped; LF opens a non-empty chunk
					if (c == hrhp_pkg::CH_LF) begin
						if (left_q != '0) begin
							st_d = hrhp_pkg::ST_CDATA;
						end
					end else if (hex[4]) begin
						left_d = hrhp_pkg::len_mac16(left_q, hex[3:0]);
					end
				end
				hrhp_pkg::ST_CDATA: begin
					bvalid = 1'b1;
					if (count_en) begin
						cons_d = cons_q + hrhp_pkg::len_t'(1);
					end
					if (left_q != '0) begin
						left_d = left_q - hrhp_pkg::len_t'(1);
					end
					// Chunk exhausted after this byte: back to the size line
					if (left_q <= hrhp_pkg::len_t'(1)) begin
						st_d = hrhp_pkg::ST_CSIZE;
					end
				end
				hrhp_pkg::ST_ERROR: begin
					st_d = hrhp_pkg::ST_ERROR;
				end
				default: begin
					st_d = hrhp_pkg::ST_ERROR;
				end
			endcase
		end
	end

	// Result word, taken from the state after this byte
	assign in_body = (st_d == hrhp_pkg::ST_BODY) || (st_d == hrhp_pkg::ST_CSIZE) ||
		(st_d == hrhp_pkg::ST_CDATA);

	always_comb begin
		res_d.phase           = hrhp_pkg::phase_code(st_d);
		res_d.body_valid      = bvalid;
		res_d.body_byte       = bvalid ? c : 8'd0;
		res_d.status_code     = code_d;
		res_d.content_length  = 32'(len_d);
		res_d.has_length      = seen_d;
		res_d.chunked         = chnk_d;
		res_d.chunk_remaining = 32'(left_d);
		res_d.body_count      = 32'(cons_d);
		res_d.body_done       = in_body && seen_d && (cons_d >= len_d);
		res_d.status_ok       = final_d;
	end

	// Advance the parser state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= hrhp_pkg::ST_PREFIX;
			pidx_q  <= '0;
			lidx_q  <= '0;
			eidx_q  <= '0;
			code_q  <= '0;
			len_q   <= '0;
			seen_q  <= 1'b0;
			chnk_q  <= 1'b0;
			left_q  <= '0;
			cons_q  <= '0;
			final_q <= 1'b0;
		end else if (accept) begin
			st_q    <= st_d;
			pidx_q  <= pidx_d;
			lidx_q  <= lidx_d;
			eidx_q  <= eidx_d;
			code_q  <= code_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			chnk_q  <= chnk_d;
			left_q  <= left_d;
			cons_q  <= cons_d;
			final_q <= final_d;
		end
	end

	// Result register: load when empty or when the held word leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !result_stall) begin
			res_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef ASSERT_OFF
	// A restart word always reports the prefix phase with no body byte
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.func == hrhp_pkg::FUNC_RESTART |=>
		result_valid && result.phase == hrhp_pkg::PH_PREFIX && !result.body_valid)
		else $error("restart did not clear the parser");

	// Body bytes only appear once the headers are over
	a_body_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.body_valid |->
		result.phase == hrhp_pkg::PH_BODY || result.phase == hrhp_pkg::PH_CSIZE ||
		result.phase == hrhp_pkg::PH_CDATA)
		else $error("body byte outside the body phases");

	// Completion needs a known content length
	a_done_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.body_done |-> result.has_length)
		else $error("body_done without a content length");

	// The error phase holds until a restart
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == hrhp_pkg::ST_ERROR && accept && item.func == hrhp_pkg::FUNC_BYTE |=>
		st_q == hrhp_pkg::ST_ERROR)
		else $error("error phase left without a restart");
`endif

endmodule

[sim/tb.sv]
// Self-checking bench for http_response_header_parser: byte stream in, one result word out.
// Depends on hrhp_pkg and the parser RTL; models the parser independently and compares
// every result word field by field under random idling and stalling on both channels.
module tb;

	// Scenario selectors for the generated responses
	localparam int SC_LENGTH     = 0;
	localparam int SC_CHUNKED    = 1;
	localparam int SC_INTERIM    = 2;
	localparam int SC_SWITCH     = 3;
	localparam int SC_SATURATE   = 4;
	localparam int SC_HUGE_CHUNK = 5;
	localparam int SC_REPEAT     = 6;
	localparam int SC_BROKEN     = 7;
	localparam int SC_MIXED      = 8;

	localparam int          STREAM_LEN  = 1550;
	localparam int          HOLD_AFTER  = 400;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [63:0] LEN_TOP     = 64'(hrhp_pkg::LEN_MAX);
	localparam logic [15:0] CODE_TOP    = 16'hFFFF;
	localparam logic [7:0]  WILD        = "?";

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	hrhp_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	hrhp_pkg::result_t result;

	// Wildcards mark the two version digits of the status prefix
	string prefix_text = "HTTP/?.? ";
	string cl_text     = "Content-Length: ";
	string te_text     = "Transfer-Encoding: chunked";
	string crlf        = "\015\n";
	string jumble_set  = "CTontes-L: rangfe";

	hrhp_pkg::item_t   byte_stream[$];
	hrhp_pkg::result_t due_results[$];

	int words_total  = 0;
	int words_taken  = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int send_idle    = 0;
	int send_calm    = 0;
	int recv_idle    = 0;
	int recv_calm    = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;

	// Parser model state
	logic [3:0]  ps_phase;
	int          ps_pidx;
	int          ps_clidx;
	int          ps_teidx;
	logic [15:0] ps_code;
	logic [63:0] ps_len;
	logic [63:0] ps_left;
	logic [63:0] ps_count;
	bit          ps_len_seen;
	bit          ps_chunked;
	bit          ps_final;

	http_response_header_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic logic [63:0] sat_mac(logic [63:0] v, logic [63:0] base,
			logic [63:0] d, logic [63:0] top);
		if (v > (top - d) / base)
			return top;
		return v * base + d;
	endfunction

	function automatic int hex_val(logic [7:0] c);
		if (c >= hrhp_pkg::CH_0 && c <= hrhp_pkg::CH_9)
			return c - hrhp_pkg::CH_0;
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	function automatic void clear_parser();
		ps_phase    = hrhp_pkg::PH_PREFIX;
		ps_pidx     = 0;
		ps_clidx    = 0;
		ps_teidx    = 0;
		ps_code     = '0;
		ps_len      = '0;
		ps_left     = '0;
		ps_count    = '0;
		ps_len_seen = 1'b0;
		ps_chunked  = 1'b0;
		ps_final    = 1'b0;
	endfunction

	// Informational codes drop back to the prefix; anything else opens the headers
	function automatic void close_status_line();
		if (ps_code < hrhp_pkg::CODE_FINAL_MIN && ps_code != hrhp_pkg::CODE_SWITCHING) begin
			ps_code  = '0;
			ps_pidx  = 0;
			ps_phase = hrhp_pkg::PH_PREFIX;
		end else begin
			ps_final = 1'b1;
			ps_clidx = 0;
			ps_teidx = 0;
			ps_phase = hrhp_pkg::PH_LINE;
		end
	endfunction

	function automatic void count_body();
		if (ps_len_seen && ps_len > 0 && ps_count < LEN_TOP)
			ps_count++;
	endfunction

	// Advance the model by one accepted word and queue the result word it must produce
	task automatic parse_word(hrhp_pkg::item_t w);
		hrhp_pkg::result_t r;
		logic [7:0]        c;
		bit                take;
		int                h;
		c    = w.rx_byte;
		take = 1'b0;
		if (w.func == hrhp_pkg::FUNC_RESTART) begin
			clear_parser();
		end else begin
			case (ps_phase) inside
				hrhp_pkg::PH_PREFIX: begin
					if (ps_pidx < prefix_text.len() && c != hrhp_pkg::CH_LF &&
					    (8'(prefix_text[ps_pidx]) == WILD ||
					     8'(prefix_text[ps_pidx]) == c)) begin
						ps_pidx++;
						if (ps_pidx >= prefix_text.len())
							ps_phase = hrhp_pkg::PH_CODE;
					end else begin
						ps_phase = hrhp_pkg::PH_ERROR;
					end
				end
				hrhp_pkg::PH_CODE: begin
					if (c >= hrhp_pkg::CH_0 && c <= hrhp_pkg::CH_9)
						ps_code = 16'(sat_mac(ps_code, 10, c - hrhp_pkg::CH_0, CODE_TOP));
					else if (c == hrhp_pkg::CH_LF)
						close_status_line();
					else
						ps_phase = hrhp_pkg::PH_REST;
				end
				hrhp_pkg::PH_REST: begin
					if (c == hrhp_pkg::CH_LF)
						close_status_line();
				end
				hrhp_pkg::PH_LINE, hrhp_pkg::PH_LEN, hrhp_pkg::PH_SKIP,
				hrhp_pkg::PH_CR: begin
					if (ps_phase == hrhp_pkg::PH_LINE) begin
						// Length matcher has priority; both advance on the same line
						if (ps_clidx < cl_text.len() && 8'(cl_text[ps_clidx]) == c) begin
							ps_clidx++;
							if (ps_clidx >= cl_text.len()) begin
								ps_phase    = hrhp_pkg::PH_LEN;
								ps_len      = '0;
								ps_count    = '0;
								ps_len_seen = 1'b1;
							end
						end else if (ps_teidx < te_text.len() &&
						             8'(te_text[ps_teidx]) == c) begin
							ps_teidx++;
							if (ps_teidx >= te_text.len()) begin
								ps_chunked = 1'b1;
								ps_phase   = hrhp_pkg::PH_SKIP;
							end
						end else if (ps_clidx == 0 && ps_teidx == 0 &&
						             c == hrhp_pkg::CH_CR) begin
							ps_phase = hrhp_pkg::PH_CR;
						end else begin
							ps_phase = hrhp_pkg::PH_SKIP;
						end
					end else if (ps_phase == hrhp_pkg::PH_LEN) begin
						if (c >= hrhp_pkg::CH_0 && c <= hrhp_pkg::CH_9)
							ps_len = sat_mac(ps_len, 10, c - hrhp_pkg::CH_0, LEN_TOP);
						else
							ps_phase = hrhp_pkg::PH_SKIP;
					end else if (ps_phase == hrhp_pkg::PH_CR && c == hrhp_pkg::CH_LF) begin
						if (ps_chunked) begin
							ps_phase = hrhp_pkg::PH_CSIZE;
							ps_left  = '0;
						end else begin
							ps_phase = hrhp_pkg::PH_BODY;
						end
					end
					if (c == hrhp_pkg::CH_LF && ps_phase != hrhp_pkg::PH_BODY &&
					    ps_phase != hrhp_pkg::PH_CSIZE) begin
						ps_phase = hrhp_pkg::PH_LINE;
						ps_clidx = 0;
						ps_teidx = 0;
					end
				end
				hrhp_pkg::PH_BODY: begin
					take = 1'b1;
					count_body();
				end
				hrhp_pkg::PH_CSIZE: begin
					if (c == hrhp_pkg::CH_LF) begin
						if (ps_left != 0)
							ps_phase = hrhp_pkg::PH_CDATA;
					end else begin
						h = hex_val(c);
						if (h >= 0)
							ps_left = sat_mac(ps_left, 16, h, LEN_TOP);
					end
				end
				hrhp_pkg::PH_CDATA: begin
					take = 1'b1;
					count_body();
					if (ps_left > 0)
						ps_left--;
					if (ps_left == 0)
						ps_phase = hrhp_pkg::PH_CSIZE;
				end
				default: begin
					ps_phase = hrhp_pkg::PH_ERROR;
				end
			endcase
		end
		r.phase           = ps_phase;
		r.body_valid      = take;
		r.body_byte       = take ? c : 8'd0;
		r.status_code     = ps_code;
		r.content_length  = ps_len[31:0];
		r.has_length      = ps_len_seen;
		r.chunked         = ps_chunked;
		r.chunk_remaining = ps_left[31:0];
		r.body_count      = ps_count[31:0];
		r.body_done       = (ps_phase == hrhp_pkg::PH_BODY || ps_phase == hrhp_pkg::PH_CSIZE ||
		                     ps_phase == hrhp_pkg::PH_CDATA) && ps_len_seen &&
		                    ps_count >= ps_len;
		r.status_ok       = ps_final;
		due_results.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result(hrhp_pkg::result_t got);
		hrhp_pkg::result_t want;
		results_seen++;
		if (due_results.size() == 0) begin
			$error("result word arrived with nothing expected");
			mismatches++;
		end else begin
			want = due_results.pop_front();
			check_field("phase", want.phase, got.phase);
			check_field("body_valid", want.body_valid, got.body_valid);
			check_field("body_byte", want.body_byte, got.body_byte);
			check_field("status_code", want.status_code, got.status_code);
			check_field("content_length", want.content_length, got.content_length);
			check_field("has_length", want.has_length, got.has_length);
			check_field("chunked", want.chunked, got.chunked);
			check_field("chunk_remaining", want.chunk_remaining, got.chunk_remaining);
			check_field("body_count", want.body_count, got.body_count);
			check_field("body_done", want.body_done, got.body_done);
			check_field("status_ok", want.status_ok, got.status_ok);
		end
	endtask

	// Mostly no gap, else short gaps, a few long ones, and now and then a calm stretch with none
	task automatic pick_idle(inout int calm, output int idle);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			idle = 0;
		end else if (roll < 2) begin
			calm = $urandom_range(20, 80);
			idle = 0;
		end else if (roll < 60) begin
			idle = 0;
		end else if (roll < 92) begin
			idle = $urandom_range(1, 3);
		end else begin
			idle = $urandom_range(8, 30);
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------

	task automatic push_byte(logic [7:0] b);
		byte_stream.push_back({hrhp_pkg::FUNC_BYTE, b});
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(8'(s[i]));
	endtask

	// The byte travelling with a restart is don't-care, so make it random
	task automatic push_restart();
		byte_stream.push_back({hrhp_pkg::FUNC_RESTART, 8'($urandom_range(0, 255))});
	endtask

	task automatic push_status(string code);
		push_text("HTTP/");
		push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'("1"));
		push_text(".");
		push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'("1"));
		push_text({" ", code});
		case ($urandom_range(0, 3))
			0: push_text({" OK", crlf});
			1: push_text(crlf);
			2: push_text("\n");
			default: push_text({" Some Reason", crlf});
		endcase
	endtask

	// Header lines that test the matchers: near misses that must not count, and full patterns with trailing junk that do
	task automatic push_misc(int k);
		case (k)
			0: push_text({"Host: a", crlf});
			1: push_text({"Transfer-Encoding: gzip", crlf});
			2: push_text({"Content-Lengthy: 7", crlf});
			3: push_text({"C", crlf});
			4: push_text({"T", crlf});
			5: push_text({"Content-Length: 12x", crlf});
			6: push_text({"content-length: 5", crlf});
			7: push_text({"Transfer-Encoding: chunkedly", crlf});
			default: begin
				repeat ($urandom_range(0, 14))
					push_byte(8'(jumble_set[$urandom_range(0, jumble_set.len() - 1)]));
				push_text(crlf);
			end
		endcase
	endtask

	task automatic push_chunk();
		int    size;
		string txt;
		size = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(1, 20);
		txt  = $urandom_range(0, 1) ? $sformatf("%0x", size) : $sformatf("%0X", size);
		if ($urandom_range(0, 3) == 0)
			txt = {"00", txt};
		if ($urandom_range(0, 3) == 0)
			txt = {txt, ";q=z"};
		push_text({txt, crlf});
		repeat (size)
			push_byte(8'($urandom_range(0, 255)));
		push_text(crlf);
	endtask

	task automatic add_response(int sc);
		logic [63:0] clen;
		string       len_txt;
		string       code;
		bit          with_len;
		bit          with_chunks;
		int          n;
		push_restart();
		if (sc == SC_BROKEN) begin
			// start well, then break off into noise
			case ($urandom_range(0, 2))
				0: push_text("HTT");
				1: push_text("HTTP/1.1 2");
				default: push_text({"HTTP/1.1 200 OK", crlf, "Content-Le"});
			endcase
			repeat ($urandom_range(1, 12))
				push_byte(8'($urandom_range(0, 255)));
			return;
		end

		if (sc == SC_INTERIM || (sc == SC_MIXED && $urandom_range(0, 3) == 0)) begin
			repeat ($urandom_range(1, 2)) begin
				case ($urandom_range(0, 3))
					0: push_status("100");
					1: push_status("102");
					2: push_status("199");
					default: push_status("");
				endcase
			end
		end

		case (sc)
			SC_SWITCH:   code = "101";
			SC_SATURATE: code = "99999999";
			default: begin
				case ($urandom_range(0, 5))
					0: code = "200";
					1: code = "204";
					2: code = "404";
					3: code = "500";
					4: code = "301";
					default: code = $sformatf("%0d", $urandom_range(200, 999));
				endcase
			end
		endcase
		push_status(code);

		with_len    = sc == SC_LENGTH || sc == SC_INTERIM || sc == SC_SATURATE ||
		              sc == SC_REPEAT || (sc == SC_MIXED && $urandom_range(0, 1) == 1);
		with_chunks = sc == SC_CHUNKED || sc == SC_HUGE_CHUNK ||
		              (sc == SC_MIXED && $urandom_range(0, 2) == 0);

		case ($urandom_range(0, 9))
			0: clen = 0;
			1: clen = 64'($urandom);
			2: clen = LEN_TOP;
			default: clen = $urandom_range(0, 40);
		endcase
		len_txt = (clen == LEN_TOP) ? "4294967296" : $sformatf("%0d", clen);
		if (sc == SC_INTERIM) begin
			clen    = 0;
			len_txt = "0";
		end else if (sc == SC_SATURATE) begin
			clen    = LEN_TOP;
			len_txt = "99999999999";
		end

		if (sc == SC_REPEAT) begin
			push_text({cl_text, $sformatf("%0d", $urandom_range(0, 99)), crlf});
			push_misc(2);
			push_misc(8);
			push_misc(3);
		end
		if (sc == SC_MIXED) begin
			repeat ($urandom_range(0, 2))
				push_misc($urandom_range(0, 8));
		end
		if (with_len)
			push_text({cl_text, len_txt, crlf});
		if (with_chunks)
			push_text({te_text, crlf});
		if (sc == SC_MIXED && $urandom_range(0, 1) == 1)
			push_misc($urandom_range(0, 8));
		push_text(crlf);

		if (with_chunks) begin
			if (sc == SC_HUGE_CHUNK) begin
				// chunk size that overflows the counter; only a few data bytes follow
				push_text({"fFfFfFfFf", crlf});
				repeat ($urandom_range(0, 10))
					push_byte(8'($urandom_range(0, 255)));
				return;
			end
			repeat ($urandom_range(0, 3))
				push_chunk();
			push_text({"0", crlf, crlf});
		end else begin
			if (clen <= 64)
				n = int'(clen) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			else
				n = $urandom_range(0, 20);
			repeat (n)
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offer words from the stream, hold them while stalled
	// ------------------------------------------------------------------

	always @(posedge clk) begin : feed_words
		hrhp_pkg::item_t next_word;
		logic            next_valid;
		next_word  = item;
		next_valid = item_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			// word taken at this edge: predict its result before offering the next
			if (item_valid && !item_stall) begin
				parse_word(item);
				words_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_idle > 0) begin
					send_idle--;
				end else if (byte_stream.size() != 0) begin
					next_word  = byte_stream.pop_front();
					next_valid = 1'b1;
					pick_idle(send_calm, send_idle);
				end
			end
		end
		// one assignment each, so a held valid never glitches low
		item_valid <= next_valid;
		item       <= next_word;
	end

	// ------------------------------------------------------------------
	// Monitor: check each result word taken, stall at random, and once hold
	// off long enough for the block to back up and stall its input
	// ------------------------------------------------------------------

	always @(posedge clk) begin : drain_results
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else if (recv_idle > 0) begin
				recv_idle--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				pick_idle(recv_calm, recv_idle);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: build the stream, reset, drain, report
	// ------------------------------------------------------------------

	initial begin : run_test
		int scenario;
		clear_parser();

		// Directed opening: prefix mismatch, error stickiness, LF at a version
		// digit, and a status line ended by LF straight after the code
		push_restart();
		push_text("HTTX");
		push_text("Z");
		push_restart();
		push_text("HTTP/\n");
		push_restart();
		push_text("HTTP/1.1 200\n");
		push_text(crlf);
		push_byte(8'hFF);
		push_byte(8'h00);

		// Walk every scenario but the mixed one once, then mostly well-formed random responses
		for (int i = 0; byte_stream.size() < STREAM_LEN; i++) begin
			if (i <= SC_BROKEN) begin
				scenario = i;
			end else begin
				case ($urandom_range(0, 19)) inside
					0, 1: scenario = SC_BROKEN;
					2, 3: scenario = $urandom_range(SC_LENGTH, SC_REPEAT);
					default: scenario = SC_MIXED;
				endcase
			end
			add_response(scenario);
		end
		words_total = byte_stream.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < words_total || due_results.size() != 0)
			@(posedge clk);
		// let any stray word surface
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
